### design/pdve_pkg.sv
// ----------------------------------------------------------------------------
// pdve_pkg
// Shared types, codes and constant tables of the pose-difference velocity
// estimator.
// ----------------------------------------------------------------------------
package pdve_pkg;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [15:0] ONE_Q14      = 16'sd16384;
  localparam logic [47:0] MIN_DT_US    = 48'd100;
  localparam int          CORDIC_STEPS = 30;
  localparam int          SQRT_STEPS   = 32;

  typedef struct packed {
    logic [2:0][31:0] pos;         // x, y, z
    logic [3:0][15:0] quat;        // w, x, y, z
    logic [47:0]      stamp;
    logic             twist_given;
  } pose_t;

  typedef struct packed {
    logic [2:0][31:0] lin;
    logic [2:0][31:0] ang;
    logic             linear_valid;
    logic             angular_valid;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_QMUL,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_CORDIC,
    ST_ANGLE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_LIN,
    OP_RATE,
    OP_ANG
  } div_op_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // Sign of term t of product component dest, with conj(q_prev) folded in.
  function automatic logic quat_term_neg(input logic [1:0] dest, input logic [1:0] t);
    logic n;
    case ({dest, t})
      4'b0100, 4'b0110, 4'b1000, 4'b1011, 4'b1100, 4'b1101: n = 1'b1;
      default: n = 1'b0;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [31:0] v;
    logic [63:0] nm;
    nm = 64'd0 - mag;
    if (neg) begin
      v = (mag > 64'h8000_0000) ? 32'h8000_0000 : nm[31:0];
    end else begin
      v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return v;
  endfunction

endpackage

### design/pdve_div.sv
// ----------------------------------------------------------------------------
// pdve_div
// Restoring unsigned divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
module pdve_div
  import pdve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] trial;
  logic        take;

  always_comb begin
    trial   = {rem_r[63:0], quo_r[63]};
    take    = trial >= {1'b0, den_r};
    rem_nxt = take ? (trial - {1'b0, den_r}) : trial;
    quo_nxt = {quo_r[62:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
        rem_r  <= 65'd0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

### design/pdve_core.sv
// ----------------------------------------------------------------------------
// pdve_core
// Sequencer and shared datapath: one multiplier, the divider, a square-root
// step and a CORDIC vectoring step, plus the stored previous pose.
// ----------------------------------------------------------------------------
module pdve_core
  import pdve_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  pose_t        pose_in,
  input  logic         out_free,
  output core_status_t status,
  output result_t      result
);

  state_t state_r, state_nxt;
  div_op_t op_r;

  pose_t             pose_r;
  logic [2:0][31:0]  prev_pos_r;
  logic [3:0][15:0]  prev_q_r;
  logic [47:0]       prev_stamp_r;
  logic              have_prev_r;

  logic [47:0]       udt_r;
  logic [1:0]        idx_r;
  logic [4:0]        cnt_r;
  result_t           res_r;

  logic signed [34:0] p_r [4];
  logic [1:0]         acc_dest_r;
  logic               acc_neg_r;
  logic [29:0]        m_r [4];
  logic [63:0]        sum_r;
  logic [63:0]        sq_r_r;
  logic [63:0]        bit_r;
  logic [30:0]        s_r;
  logic signed [39:0] x_r, y_r;
  logic signed [35:0] z_r;
  logic [33:0]        rate_r;
  logic [63:0]        prod_r;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p;
  logic               div_start;
  logic [63:0]        div_num, div_den;
  logic               div_done;
  logic [63:0]        div_quot;

  logic signed [32:0] d_s   [3];
  logic [32:0]        d_mag [3];
  logic [15:0]        qc    [4];
  logic [15:0]        qp    [4];
  logic               est_ok;
  logic [3:0]         qn;
  logic [1:0]         q_dest, q_t;
  logic [33:0]        p_mag [4];
  logic [33:0]        p_or;
  logic [1:0]         k_sh;
  logic [63:0]        sq_trial;
  logic [63:0]        sq_r_next;
  logic               sq_take;
  logic               cordic_up;
  logic [36:0]        z2;

  pdve_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Operand preparation.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_s[i]   = {pose_r.pos[i][31], pose_r.pos[i]} - {prev_pos_r[i][31], prev_pos_r[i]};
      d_mag[i] = d_s[i][32] ? (33'd0 - d_s[i]) : d_s[i];
    end
    for (int i = 0; i < 4; i++) begin
      qc[i] = pose_r.quat[i];
      qp[i] = prev_q_r[i];
    end
    // A zero quaternion stands for the identity rotation.
    if (pose_r.quat == '0) qc[0] = ONE_Q14;
    if (prev_q_r == '0)    qp[0] = ONE_Q14;
    est_ok = !pose_r.twist_given && have_prev_r &&
             ({1'b0, pose_r.stamp} > ({1'b0, prev_stamp_r} + {1'b0, MIN_DT_US}));
    qn     = cnt_r[3:0];
    q_dest = qn[3:2];
    q_t    = qn[1:0];
    for (int i = 0; i < 4; i++) begin
      p_mag[i] = p_r[i][34] ? 34'(35'd0 - p_r[i]) : p_r[i][33:0];
    end
    p_or = p_mag[0] | p_mag[1] | p_mag[2] | p_mag[3];
    if (p_or[32])      k_sh = 2'd3;
    else if (p_or[31]) k_sh = 2'd2;
    else if (p_or[30]) k_sh = 2'd1;
    else               k_sh = 2'd0;
    sq_trial  = sq_r_r + bit_r;
    sq_take   = sum_r >= sq_trial;
    sq_r_next = sq_take ? ((sq_r_r >> 1) + bit_r) : (sq_r_r >> 1);
    cordic_up = y_r > 40'sd0;
    z2        = {z_r, 1'b0};
  end

  assign mul_p = mul_a * mul_b;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = est_ok ? ST_MUL : ST_DONE;
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          case (op_r)
            OP_LIN:  state_nxt = (idx_r == 2'd2) ? ST_QMUL : ST_MUL;
            OP_RATE: state_nxt = ST_MUL;
            default: state_nxt = (idx_r == 2'd2) ? ST_DONE : ST_MUL;
          endcase
        end
      end
      ST_QMUL:   if (cnt_r == 5'd16) state_nxt = ST_NORM;
      ST_NORM:   state_nxt = ST_SQ;
      ST_SQ:     if (cnt_r == 5'd3) state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == 5'(SQRT_STEPS - 1))
          state_nxt = (sq_r_next == 64'd0) ? ST_DONE : ST_CORDIC;
      end
      ST_CORDIC: if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_ANGLE;
      ST_ANGLE:  state_nxt = ($signed(z2) > 37'sd1) ? ST_MUL : ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Unit controls.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      ST_MUL: begin
        case (op_r)
          OP_LIN: begin
            mul_a = {2'b0, d_mag[idx_r]};
            mul_b = {15'b0, USEC_PER_SEC};
          end
          OP_RATE: begin
            mul_a = {1'b0, z_r[32:0], 1'b0};
            mul_b = {15'b0, USEC_PER_SEC};
          end
          default: begin
            mul_a = {5'b0, m_r[2'd1 + idx_r]};
            mul_b = {1'b0, rate_r};
          end
        endcase
      end
      ST_QMUL: begin
        mul_a = {{19{qc[q_t][15]}}, qc[q_t]};
        mul_b = {{19{qp[q_dest ^ q_t][15]}}, qp[q_dest ^ q_t]};
      end
      ST_SQ: begin
        mul_a = {5'b0, m_r[2'(cnt_r) + 2'd1]};
        mul_b = {5'b0, m_r[2'(cnt_r) + 2'd1]};
      end
      ST_DSTART: begin
        div_start = 1'b1;
        case (op_r)
          OP_LIN: begin
            div_num = prod_r + {17'b0, udt_r[47:1]};
            div_den = {16'b0, udt_r};
          end
          OP_RATE: begin
            div_num = prod_r + {3'b0, udt_r, 13'b0};
            div_den = {2'b0, udt_r, 14'b0};
          end
          default: begin
            div_num = prod_r + {34'b0, s_r[30:1]};
            div_den = {33'b0, s_r};
          end
        endcase
      end
      default: ;
    endcase
    status.idle = (state_r == ST_IDLE);
    status.done = (state_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      have_prev_r  <= 1'b0;
      prev_pos_r   <= '0;
      prev_q_r     <= '0;
      prev_stamp_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (start) pose_r <= pose_in;
        end
        ST_CHECK: begin
          res_r <= '{lin: '0, ang: '0, linear_valid: est_ok, angular_valid: 1'b0};
          udt_r <= pose_r.stamp - prev_stamp_r;
          op_r  <= OP_LIN;
          idx_r <= 2'd0;
          cnt_r <= 5'd0;
          for (int i = 0; i < 4; i++) p_r[i] <= '0;
        end
        ST_DWAIT: begin
          if (div_done) begin
            case (op_r)
              OP_LIN: begin
                res_r.lin[idx_r] <= sat_mag(div_quot, d_s[idx_r][32]);
                idx_r            <= idx_r + 2'd1;
              end
              OP_RATE: begin
                rate_r <= div_quot[33:0];
                op_r   <= OP_ANG;
                idx_r  <= 2'd0;
              end
              default: begin
                res_r.ang[idx_r] <= sat_mag(div_quot,
                                            p_r[2'd1 + idx_r][34] != p_r[0][34]);
                idx_r            <= idx_r + 2'd1;
              end
            endcase
          end
        end
        ST_QMUL: begin
          // The product issued last cycle lands in prod_r now.
          if (cnt_r != 5'd0) begin
            p_r[acc_dest_r] <= acc_neg_r ? (p_r[acc_dest_r] - $signed(prod_r[34:0]))
                                         : (p_r[acc_dest_r] + $signed(prod_r[34:0]));
          end
          acc_dest_r <= q_dest;
          acc_neg_r  <= quat_term_neg(q_dest, q_t);
          cnt_r      <= (cnt_r == 5'd16) ? 5'd0 : cnt_r + 5'd1;
        end
        ST_NORM: begin
          for (int i = 0; i < 4; i++) m_r[i] <= 30'(p_mag[i] >> k_sh);
          sum_r <= '0;
        end
        ST_SQ: begin
          if (cnt_r != 5'd0) sum_r <= sum_r + prod_r;
          cnt_r  <= (cnt_r == 5'd3) ? 5'd0 : cnt_r + 5'd1;
          sq_r_r <= '0;
          bit_r  <= 64'd1 << 62;
        end
        ST_SQRT: begin
          if (sq_take) sum_r <= sum_r - sq_trial;
          sq_r_r <= sq_r_next;
          bit_r  <= bit_r >> 2;
          cnt_r  <= (cnt_r == 5'(SQRT_STEPS - 1)) ? 5'd0 : cnt_r + 5'd1;
          if (cnt_r == 5'(SQRT_STEPS - 1)) begin
            s_r   <= sq_r_next[30:0];
            x_r   <= {10'b0, m_r[0]};
            y_r   <= {9'b0, sq_r_next[30:0]};
            z_r   <= '0;
          end
        end
        ST_CORDIC: begin
          if (cordic_up) begin
            x_r <= x_r + (y_r >>> cnt_r);
            y_r <= y_r - (x_r >>> cnt_r);
            z_r <= z_r + $signed({5'b0, atan_q30(cnt_r)});
          end else begin
            x_r <= x_r - (y_r >>> cnt_r);
            y_r <= y_r + (x_r >>> cnt_r);
            z_r <= z_r - $signed({5'b0, atan_q30(cnt_r)});
          end
          cnt_r <= cnt_r + 5'd1;
        end
        ST_ANGLE: begin
          if ($signed(z2) > 37'sd1) begin
            res_r.angular_valid <= 1'b1;
            op_r                <= OP_RATE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            prev_pos_r   <= pose_r.pos;
            prev_q_r     <= pose_r.quat;
            prev_stamp_r <= pose_r.stamp;
            have_prev_r  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign result = res_r;

endmodule

### design/pose_difference_velocity_estimator.sv
// ----------------------------------------------------------------------------
// pose_difference_velocity_estimator
// Linear and angular velocity from the difference of successive poses.
//
//   channel  dir  data                                 user
//   in_      in   pos x,y,z; quat w,x,y,z; stamp_us    twist_given
//   out_     out  lin_vx,vy,vz; ang_wx,wy,wz           linear_valid, angular_valid
//
// An item without an estimate skips the arithmetic; one with a linear estimate
// runs the 64-step divider once per linear axis, then the quaternion product,
// the square root and, unless the square root is zero, the CORDIC; one with an
// angular rate runs the divider also once for the rate and once per angular
// axis. Reset is synchronous and clears the previous pose.
// in_tready is high only while the sequencer is idle; a finished result waits
// in the output register and a stalled out_tready holds the next result back.
// ----------------------------------------------------------------------------
module pose_difference_velocity_estimator
  import pdve_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, stamp_us
  input  logic [207:0] in_tdata,
  // twist_given
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // lin_vx, lin_vy, lin_vz, ang_wx, ang_wy, ang_wz
  output logic [191:0] out_tdata,
  // linear_valid, angular_valid
  output logic [1:0]   out_tuser
);

  pose_t        pose;
  result_t      res;
  core_status_t status;
  logic         out_valid_r;
  logic [191:0] out_data_r;
  logic [1:0]   out_user_r;
  logic         out_free;

  assign pose.pos         = in_tdata[95:0];
  assign pose.quat        = in_tdata[159:96];
  assign pose.stamp       = in_tdata[207:160];
  assign pose.twist_given = in_tuser[0];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = status.idle;

  pdve_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_tvalid && status.idle),
    .pose_in  (pose),
    .out_free (out_free),
    .status   (status),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (status.done && out_free) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {res.ang, res.lin};
      out_user_r  <= {res.angular_valid, res.linear_valid};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### design/pdve_checker.sv
// ----------------------------------------------------------------------------
// pdve_checker
// Port-level checks of the velocity estimator, bound to the top level.
// ----------------------------------------------------------------------------
module pdve_checker
  import pdve_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic [1:0]   out_tuser
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item shown right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("block ready again directly after accepting an item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result item changed");

  a_no_est_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("nonzero result without a linear estimate");

  a_no_ang_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata[191:96] == '0))
    else $error("nonzero angular rate without angular_valid");

endmodule

bind pose_difference_velocity_estimator pdve_checker u_pdve_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
